### sv/clwseq_pkg.sv
package clwseq_pkg;

   localparam logic [1:0] REQ_COMMAND  = 2'd0;
   localparam logic [1:0] REQ_DATA     = 2'd1;
   localparam logic [1:0] REQ_POSITION = 2'd2;

   localparam logic [1:0] CSR_NIBBLE_MODE      = 2'd0;
   localparam logic [1:0] CSR_ENABLE_HOLD      = 2'd1;
   localparam logic [1:0] CSR_COMMAND_SETTLE   = 2'd2;

   localparam logic [2:0] ROW_FIRST  = 3'd1;
   localparam logic [2:0] ROW_SECOND = 3'd2;
   localparam logic [2:0] ROW_FOURTH = 3'd4;

   localparam logic [7:0] ROW_FIRST_BASE  = 8'h80;
   localparam logic [7:0] ROW_SECOND_BASE = 8'hC0;
   localparam logic [7:0] ROW_FOURTH_BASE = 8'hE0;
   localparam logic [7:0] COLUMN_OFFSET   = 8'h01;

   localparam logic [15:0] ENABLE_HOLD_RESET    = 16'd200;
   localparam logic [15:0] COMMAND_SETTLE_RESET = 16'd1000;

   typedef struct packed {
      logic        nibble_mode;
      logic [15:0] enable_hold_ticks;
      logic [15:0] command_settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic       register_select;
      logic [7:0] data_byte;
   } xfer_type;

   typedef struct packed {
      logic        register_select;
      logic [7:0]  data_lines;
      logic        enable_level;
      logic [15:0] hold_ticks;
      logic        last_event;
   } evt_type;

endpackage

### sv/clwseq_csr.sv
module clwseq_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_write_data,
   output clwseq_pkg::cfg_type   cfg
);
   import clwseq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NIBBLE_MODE:    cfg_in.nibble_mode          = csr_write_data[0];
            CSR_ENABLE_HOLD:    cfg_in.enable_hold_ticks    = csr_write_data;
            CSR_COMMAND_SETTLE: cfg_in.command_settle_ticks = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nibble_mode          <= 1'b0;
         cfg_ff.enable_hold_ticks    <= ENABLE_HOLD_RESET;
         cfg_ff.command_settle_ticks <= COMMAND_SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/clwseq_decode.sv
module clwseq_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_byte_value,
   input  logic [2:0]            req_row,
   input  logic [7:0]            req_column,
   output logic                  dec_valid,
   output clwseq_pkg::xfer_type  dec_xfer,
   input  logic                  dec_take
);
   import clwseq_pkg::*;

   logic     dec_valid_ff;
   logic     dec_valid_in;
   xfer_type dec_xfer_ff;
   xfer_type dec_xfer_in;
   logic     has_events;
   logic     req_accept;
   logic [7:0] row_base;
   logic       row_known;

   assign req_stall  = dec_valid_ff && !dec_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      row_known = 1'b1;
      case (req_row)
         ROW_FIRST:  row_base = ROW_FIRST_BASE;
         ROW_SECOND: row_base = ROW_SECOND_BASE;
         ROW_FOURTH: row_base = ROW_FOURTH_BASE;
         default: begin
            row_base  = ROW_FIRST_BASE;
            row_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      dec_xfer_in.register_select = 1'b0;
      dec_xfer_in.data_byte       = req_byte_value;
      has_events                  = 1'b1;
      case (req_type)
         REQ_COMMAND: dec_xfer_in.register_select = 1'b0;
         REQ_DATA:    dec_xfer_in.register_select = 1'b1;
         REQ_POSITION: begin
            // The column is one-based; the subtraction wraps at eight bits.
            dec_xfer_in.data_byte = row_base + (req_column - COLUMN_OFFSET);
            has_events            = row_known;
         end
         default: has_events = 1'b0;
      endcase
   end

   always_comb begin
      if (req_accept) begin
         dec_valid_in = has_events;
      end else if (dec_take) begin
         dec_valid_in = 1'b0;
      end else begin
         dec_valid_in = dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dec_xfer_ff <= dec_xfer_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec_xfer  = dec_xfer_ff;

endmodule

### sv/clwseq_emit.sv
module clwseq_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  clwseq_pkg::cfg_type   cfg,
   input  logic                  dec_valid,
   input  clwseq_pkg::xfer_type  dec_xfer,
   output logic                  dec_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output clwseq_pkg::evt_type   rsp_evt
);
   import clwseq_pkg::*;

   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   evt_type  evt_ff;
   evt_type  evt_in;
   xfer_type xfer_ff;
   xfer_type xfer_in;
   logic [1:0] step_ff;
   logic [1:0] step_in;
   logic     advance;
   logic     more;

   // Step bit 0 selects the enable-low half of a transfer; in four-bit mode
   // step bit 1 selects the low nibble.
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign more     = rsp_valid_ff && !evt_ff.last_event;
   assign dec_take = advance && !more;

   always_comb begin
      if (more) begin
         xfer_in      = xfer_ff;
         step_in      = step_ff + 2'd1;
         rsp_valid_in = 1'b1;
      end else begin
         xfer_in      = dec_xfer;
         step_in      = 2'd0;
         rsp_valid_in = dec_valid;
      end
   end

   always_comb begin
      evt_in.register_select = xfer_in.register_select;
      evt_in.enable_level    = !step_in[0];
      if (cfg.nibble_mode) begin
         evt_in.data_lines = step_in[1] ? {xfer_in.data_byte[3:0], 4'h0}
                                        : {xfer_in.data_byte[7:4], 4'h0};
         evt_in.last_event = (step_in == 2'd3);
      end else begin
         evt_in.data_lines = xfer_in.data_byte;
         evt_in.last_event = (step_in == 2'd1);
      end
      if (evt_in.enable_level) begin
         evt_in.hold_ticks = cfg.enable_hold_ticks;
      end else if (evt_in.last_event && !xfer_in.register_select) begin
         evt_in.hold_ticks = cfg.command_settle_ticks;
      end else begin
         evt_in.hold_ticks = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         evt_ff  <= evt_in;
         xfer_ff <= xfer_in;
         step_ff <= step_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_evt   = evt_ff;

endmodule

### sv/char_lcd_write_sequencer_core.sv
// Character LCD write sequencer.
// A request item on the req_ channel (command byte, data byte or cursor
// position) becomes a series of pin event items on the rsp_ channel: each
// transfer is an enable-high event followed by an enable-low event, and each
// event carries the number of ticks its pin levels must be held.
// Eight-bit mode gives two events per request, four-bit mode gives four.
// Position requests for rows other than 1, 2 and 4, and unknown request
// types, are taken and give no events.
// The input register takes the request at the accepting edge, and the output
// register takes its first event once it has finished the previous request.
// The output register gives one event per cycle while rsp_stall is low; while
// it works through the events of a request (two in eight-bit mode, four in
// four-bit mode), the next request waits in the input register.
// The csr_ port writes the mode and timing registers; write it only while
// no request is in flight. Reset clears both stages and restores the
// register defaults (eight-bit, 200 hold ticks, 1000 settle ticks).
// When rsp_stall is high the current event holds, and req_stall rises once
// the input register is full.
module char_lcd_write_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_byte_value,
   input  logic [2:0]  req_row,
   input  logic [7:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_register_select,
   output logic [7:0]  rsp_data_lines,
   output logic        rsp_enable_level,
   output logic [15:0] rsp_hold_ticks,
   output logic        rsp_last_event
);
   import clwseq_pkg::*;

   cfg_type  cfg;
   xfer_type dec_xfer;
   evt_type  rsp_evt;
   logic     dec_valid;
   logic     dec_take;

   clwseq_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   clwseq_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .dec_valid      (dec_valid),
      .dec_xfer       (dec_xfer),
      .dec_take       (dec_take)
   );

   clwseq_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .dec_valid (dec_valid),
      .dec_xfer  (dec_xfer),
      .dec_take  (dec_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_evt   (rsp_evt)
   );

   assign rsp_register_select = rsp_evt.register_select;
   assign rsp_data_lines      = rsp_evt.data_lines;
   assign rsp_enable_level    = rsp_evt.enable_level;
   assign rsp_hold_ticks      = rsp_evt.hold_ticks;
   assign rsp_last_event      = rsp_evt.last_event;

endmodule

### sv/clwseq_checker.sv
module clwseq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_register_select,
   input logic [7:0]  rsp_data_lines,
   input logic        rsp_enable_level,
   input logic [15:0] rsp_hold_ticks,
   input logic        rsp_last_event
);

   // A stalled event stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_lines)
         && $stable(rsp_hold_ticks) && $stable(rsp_enable_level))
      else $error("stalled event changed");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("event valid after reset");

   // Every request ends on an enable-low event.
   a_last_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_level |-> !rsp_last_event)
      else $error("request ended with enable high");

   // The enable-low half of a transfer follows its high half at once.
   a_pulse_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_enable_level |=>
         rsp_valid && !rsp_enable_level && $stable(rsp_data_lines)
         && $stable(rsp_register_select))
      else $error("enable-low event missing after enable-high");

   // A data request finishes without a settle time.
   a_data_no_settle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_event && rsp_register_select |-> rsp_hold_ticks == 16'd0)
      else $error("data request carries a settle time");

endmodule

bind char_lcd_write_sequencer_core clwseq_checker u_clwseq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_register_select (rsp_register_select),
   .rsp_data_lines      (rsp_data_lines),
   .rsp_enable_level    (rsp_enable_level),
   .rsp_hold_ticks      (rsp_hold_ticks),
   .rsp_last_event      (rsp_last_event)
);
